[sv/sit_pkg.sv]
// ============================================================================
// sit_pkg
// Shared types and constants for the sorted insert table.
// ============================================================================
package sit_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LIST   = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_ENTRY    = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;      // capture the item's value
        logic    idx_top;   // index := fill count
        logic    idx_zero;  // index := 0
        logic    idx_dec;
        logic    idx_inc;
        logic    rd_en;
        logic    rd_prev;   // read at index - 1 rather than at index
        logic    wr_shift;  // entry[index] := read data
        logic    wr_value;  // entry[index] := captured value
        logic    cnt_inc;
        logic    out_en;
        status_t out_kind;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic idx_last;     // index addresses the highest stored entry
        logic greater;      // read data is greater than the captured value
    } dp_status_t;

endpackage

[sv/sit_ram.sv]
// ============================================================================
// sit_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module sit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/sit_dp.sv]
// ============================================================================
// sit_dp
// Datapath: entry RAM, fill count, index, captured value and result register.
// ============================================================================
module sit_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sit_pkg::ctrl_cmd_t                  cmd_i,
    input  logic signed [sit_pkg::DATA_W-1:0]   value_in,
    output sit_pkg::dp_status_t                 sts,
    output logic                                out_valid,
    output logic signed [sit_pkg::DATA_W-1:0]   out_data,
    output sit_pkg::status_t                    out_status,
    output logic                                out_last
);

    logic [sit_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [sit_pkg::ADDR_W-1:0]        idx_reg, idx_next;
    logic signed [sit_pkg::DATA_W-1:0] value_reg;
    logic signed [sit_pkg::DATA_W-1:0] rdata;
    logic [sit_pkg::DATA_W-1:0]        rdata_raw;
    logic [sit_pkg::ADDR_W-1:0]        raddr;
    logic [sit_pkg::DATA_W-1:0]        wdata;
    logic                              we;
    logic [sit_pkg::CNT_W-1:0]         idx_plus1;

    logic                              valid_reg;
    logic signed [sit_pkg::DATA_W-1:0] data_reg, data_next;
    sit_pkg::status_t                  status_reg;
    logic                              last_reg, last_next;

    assign raddr = cmd_i.rd_prev ? idx_reg - sit_pkg::ADDR_W'(1) : idx_reg;
    assign we    = cmd_i.wr_shift | cmd_i.wr_value;
    assign wdata = cmd_i.wr_shift ? rdata_raw : value_reg;
    assign rdata = $signed(rdata_raw);

    sit_ram #(
        .WIDTH (sit_pkg::DATA_W),
        .DEPTH (sit_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (idx_reg),
        .wdata (wdata),
        .re    (cmd_i.rd_en),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign idx_plus1 = sit_pkg::CNT_W'(idx_reg) + sit_pkg::CNT_W'(1);

    assign sts.full     = (count_reg == sit_pkg::CNT_W'(sit_pkg::DEPTH));
    assign sts.empty    = (count_reg == '0);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.idx_last = (idx_plus1 == count_reg);
    assign sts.greater  = (rdata > value_reg);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd_i.idx_top)
        begin
            idx_next = count_reg[sit_pkg::ADDR_W-1:0];
        end
        else if (cmd_i.idx_zero)
        begin
            idx_next = '0;
        end
        else if (cmd_i.idx_dec)
        begin
            idx_next = idx_reg - sit_pkg::ADDR_W'(1);
        end
        else if (cmd_i.idx_inc)
        begin
            idx_next = idx_reg + sit_pkg::ADDR_W'(1);
        end
        count_next = cmd_i.cnt_inc ? count_reg + sit_pkg::CNT_W'(1) : count_reg;
    end

    always_comb
    begin
        last_next = 1'b1;
        case (cmd_i.out_kind)
            sit_pkg::ST_INSERTED: data_next = value_reg;
            sit_pkg::ST_FULL:     data_next = value_in;
            sit_pkg::ST_ENTRY:
            begin
                data_next = rdata;
                last_next = sts.idx_last;
            end
            default:              data_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= cmd_i.out_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            value_reg <= value_in;
        end
        if (cmd_i.out_en)
        begin
            data_reg   <= data_next;
            status_reg <= cmd_i.out_kind;
            last_reg   <= last_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_data   = data_reg;
    assign out_status = status_reg;
    assign out_last   = last_reg;

endmodule

[sv/sit_ctrl.sv]
// ============================================================================
// sit_ctrl
// Controller: sequences the insert shift and the list read-out.
// ============================================================================
module sit_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    input  sit_pkg::dp_status_t sts,
    output sit_pkg::ctrl_cmd_t  cmd_o,
    output logic                busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_LST_RD,
        S_LST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd_o          = '0;
        cmd_o.out_kind = sit_pkg::ST_INSERTED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == sit_pkg::CMD_INSERT)
                    begin
                        if (sts.full)
                        begin
                            cmd_o.out_en   = 1'b1;
                            cmd_o.out_kind = sit_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd_o.load    = 1'b1;
                            cmd_o.idx_top = 1'b1;
                            state_next    = S_INS_CHK;
                        end
                    end
                    else if (sts.empty)
                    begin
                        cmd_o.out_en   = 1'b1;
                        cmd_o.out_kind = sit_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd_o.idx_zero = 1'b1;
                        state_next     = S_LST_RD;
                    end
                end
            end
            S_INS_CHK:
            begin
                // At the bottom of the table the value simply goes in place.
                if (sts.idx_zero)
                begin
                    cmd_o.wr_value = 1'b1;
                    cmd_o.cnt_inc  = 1'b1;
                    cmd_o.out_en   = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd_o.rd_en   = 1'b1;
                    cmd_o.rd_prev = 1'b1;
                    state_next    = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                // A larger entry moves up one place; an equal or smaller one stops the shift.
                if (sts.greater)
                begin
                    cmd_o.wr_shift = 1'b1;
                    cmd_o.idx_dec  = 1'b1;
                    state_next     = S_INS_CHK;
                end
                else
                begin
                    cmd_o.wr_value = 1'b1;
                    cmd_o.cnt_inc  = 1'b1;
                    cmd_o.out_en   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LST_RD:
            begin
                cmd_o.rd_en = 1'b1;
                state_next  = S_LST_OUT;
            end
            S_LST_OUT:
            begin
                cmd_o.out_en   = 1'b1;
                cmd_o.out_kind = sit_pkg::ST_ENTRY;
                if (sts.idx_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd_o.idx_inc = 1'b1;
                    state_next    = S_LST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[sv/sorted_insert_table_core.sv]
// ============================================================================
// sorted_insert_table_core
// Table of up to DEPTH signed values kept in ascending order.
// ============================================================================
// Usage:
//   An item is taken when start is high while busy is low; cmd selects insert
//   or list, value carries the number to insert. Each result appears on data,
//   status and last for exactly one cycle with valid high; the receiver must
//   take it then, as there is no back-pressure.
//   Insert: the value goes after any equal entries. Larger entries are moved
//   up one at a time from the top through the single read port of the entry
//   RAM, each read and then written one place higher (at most DEPTH-1
//   entries moved). Its result is shown in the first cycle with busy low
//   again. A full table refuses at once: the result follows in the next
//   cycle, and busy never rises.
//   List: the entries are read and shown one at a time from the bottom of
//   the table up, each through a read state and then an output state, with
//   busy high throughout. An empty table gives one empty result in the next
//   cycle. Reset empties the table; the entry RAM itself is not cleared, as
//   only positions below the fill count are ever read.
// ============================================================================
module sorted_insert_table_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic signed [sit_pkg::DATA_W-1:0] value,
    output logic                              valid,
    output logic signed [sit_pkg::DATA_W-1:0] data,
    output logic [1:0]                        status,
    output logic                              last
);

    sit_pkg::ctrl_cmd_t  ctl;
    sit_pkg::dp_status_t sts;
    sit_pkg::status_t    out_status;

    sit_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .cmd_o (ctl),
        .busy  (busy)
    );

    sit_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_i      (ctl),
        .value_in   (value),
        .sts        (sts),
        .out_valid  (valid),
        .out_data   (data),
        .out_status (out_status),
        .out_last   (last)
    );

    assign status = out_status;

    // Only a listed entry can be followed by further results of the same item.
    a_not_last_is_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid && !last) |-> (status == sit_pkg::ST_ENTRY)
    ) else $error("non-final result is not a listed entry");

    // A refusal is only ever given when the table is full.
    a_refuse_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid && status == sit_pkg::ST_FULL) |-> sts.full
    ) else $error("insert refused while table not full");

    // An accepted item either starts work or answers in the next cycle.
    a_item_progress: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || valid)
    ) else $error("accepted item produced neither work nor result");

endmodule
